// ===== design/segint_pkg.sv =====
// ----------------------------------------------------------------------------
// segint_pkg
// Shared types, codes and helpers of the 2-D segment intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package segint_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CW       = 16;  // coordinate port width
  localparam int INT_BITS = 16;  // integer bits of a crossing point magnitude
  localparam int MAG_W    = 51;  // numerator magnitude width
  localparam int DEN_W    = 34;  // denominator magnitude width

  localparam logic [1:0] KIND_EMPTY   = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_OVERLAP = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] ov_sx;
    logic signed [CW-1:0] ov_sy;
    logic signed [CW-1:0] ov_ex;
    logic signed [CW-1:0] ov_ey;
  } seg_tag_t;

  // lexicographic a < b, x first
  function automatic logic lex_lt(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                  input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by);
    return (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  // apply sign and clamp to 32-bit signed
  function automatic logic [31:0] sat_fix(input logic [63:0] v, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (v > 64'h8000_0000) r = 32'h8000_0000;
      else                   r = 32'(64'd0 - v);
    end else begin
      if (v > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                   r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/segment_intersection_2d_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d_core
// Classifies the intersection of two integer segments: empty, one crossing
// point in fixed point, or a collinear overlap segment.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   in      | in_valid_i, in_stall_o, 8 xy | into core
//   out     | out_valid_o, out_stall_i     | out of core
//
// One pair per cycle while out_stall_i does not hold a result. The pipeline has
// eight arithmetic stages, one divider stage per quotient bit and one output register.
// The whole pipeline freezes while a result waits under out_stall_i.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_2d_core #(
  parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [segint_pkg::CW-1:0] first_start_x_i,
  input  wire logic signed [segint_pkg::CW-1:0] first_start_y_i,
  input  wire logic signed [segint_pkg::CW-1:0] first_end_x_i,
  input  wire logic signed [segint_pkg::CW-1:0] first_end_y_i,
  input  wire logic signed [segint_pkg::CW-1:0] second_start_x_i,
  input  wire logic signed [segint_pkg::CW-1:0] second_start_y_i,
  input  wire logic signed [segint_pkg::CW-1:0] second_end_x_i,
  input  wire logic signed [segint_pkg::CW-1:0] second_end_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          kind_o,
  output logic signed [31:0]                  point_x_o,
  output logic signed [31:0]                  point_y_o,
  output logic signed [segint_pkg::CW-1:0]    overlap_start_x_o,
  output logic signed [segint_pkg::CW-1:0]    overlap_start_y_o,
  output logic signed [segint_pkg::CW-1:0]    overlap_end_x_o,
  output logic signed [segint_pkg::CW-1:0]    overlap_end_y_o
);
  import segint_pkg::*;

  localparam int EB = (COORD_BITS < CW) ? COORD_BITS : CW;
  localparam int SH = CW - EB;
  localparam int QB = INT_BITS + FRAC_BITS;

  logic en;
  logic [7:0] vld_q;

  // stage 1
  logic signed [CW-1:0] in_w [8];
  logic signed [CW-1:0] p_d [8];
  logic signed [CW-1:0] p1_q [8];
  logic signed [CW:0]   ab1_q [4];   // a1 b1 a2 b2
  logic signed [CW:0]   dd1_q [6];   // dx31 dy31 dx41 dy41 dx23 dy23
  // stage 2
  logic signed [31:0]   pc2_q [4];
  logic signed [33:0]   pd2_q [2];
  logic signed [33:0]   px2_q [8];
  logic signed [CW:0]   ab2_q [4];
  logic signed [CW-1:0] lh2_q [8];
  logic signed [CW-1:0] or2_q [8];
  // stage 3
  logic signed [32:0]   c1_3_q, c2_3_q;
  logic signed [34:0]   d3_q;
  logic                 col3_q, ok3_q;
  logic signed [CW:0]   ab3_q [4];
  logic signed [CW-1:0] lh3_q [8];
  logic signed [CW-1:0] ov3_q [4];
  // stage 4
  logic signed [49:0]   q4_q [4];
  logic signed [34:0]   d4_q;
  logic                 col4_q, ok4_q;
  logic signed [CW-1:0] lh4_q [8];
  logic signed [CW-1:0] ov4_q [4];
  // stage 5
  logic signed [50:0]   xn5_q, yn5_q;
  logic signed [34:0]   d5_q;
  logic                 col5_q, ok5_q;
  logic signed [CW-1:0] lh5_q [8];
  logic signed [CW-1:0] ov5_q [4];
  // stage 6
  logic signed [50:0]   xn6_q, yn6_q;
  logic signed [34:0]   den6_q;
  logic                 dnz6_q, col6_q, ok6_q;
  logic signed [CW-1:0] lh6_q [8];
  logic signed [CW-1:0] ov6_q [4];
  // stage 7
  logic signed [51:0]   rp7_q [8];
  logic signed [50:0]   xn7_q, yn7_q;
  logic signed [34:0]   den7_q;
  logic                 dnz7_q, col7_q, ok7_q;
  logic signed [CW-1:0] ov7_q [4];
  // stage 8
  logic [MAG_W-1:0]     mx8_q, my8_q;
  logic [DEN_W-1:0]     den8_q;
  seg_tag_t             tag8_q;

  logic signed [CW-1:0] ov3_d [4];
  logic                 ok3_d, col3_d;
  seg_tag_t             tag8_d;
  logic                 inr8;

  logic                 dv_valid;
  logic [QB-1:0]        dv_qx, dv_qy;
  seg_tag_t             dv_tag;

  logic                 out_valid_q;
  logic [1:0]           kind_q;
  logic signed [31:0]   px_q, py_q;
  logic signed [CW-1:0] ov_q [4];

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign in_w[0] = first_start_x_i;
  assign in_w[1] = first_start_y_i;
  assign in_w[2] = first_end_x_i;
  assign in_w[3] = first_end_y_i;
  assign in_w[4] = second_start_x_i;
  assign in_w[5] = second_start_y_i;
  assign in_w[6] = second_end_x_i;
  assign in_w[7] = second_end_y_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      p_d[i] = (in_w[i] <<< SH) >>> SH;
    end
  end

  // overlap endpoints and collinearity
  always_comb begin
    logic signed [34:0] cs [4];
    if (lex_lt(or2_q[0], or2_q[1], or2_q[4], or2_q[5])) begin
      ov3_d[0] = or2_q[4];
      ov3_d[1] = or2_q[5];
    end else begin
      ov3_d[0] = or2_q[0];
      ov3_d[1] = or2_q[1];
    end
    if (lex_lt(or2_q[2], or2_q[3], or2_q[6], or2_q[7])) begin
      ov3_d[2] = or2_q[2];
      ov3_d[3] = or2_q[3];
    end else begin
      ov3_d[2] = or2_q[6];
      ov3_d[3] = or2_q[7];
    end
    ok3_d = !lex_lt(ov3_d[2], ov3_d[3], ov3_d[0], ov3_d[1]);
    for (int i = 0; i < 4; i++) begin
      cs[i] = 35'(px2_q[2*i]) + 35'(px2_q[2*i+1]);
    end
    col3_d = (cs[0] == '0) && (cs[1] == '0) && (cs[2] == '0) && (cs[3] == '0);
  end

  // bounding box test and classification
  always_comb begin
    logic signed [50:0] nm;
    logic               neg_x, neg_y;
    inr8 = 1'b1;
    for (int j = 0; j < 4; j++) begin
      nm = ((j % 2) == 0) ? xn7_q : yn7_q;
      if (!((rp7_q[2*j] <= 52'(nm)) && (52'(nm) <= rp7_q[2*j+1]))) inr8 = 1'b0;
    end
    neg_x = xn7_q < 0;
    neg_y = yn7_q < 0;
    tag8_d = '0;
    tag8_d.neg_x = neg_x;
    tag8_d.neg_y = neg_y;
    if (dnz7_q) begin
      tag8_d.kind = inr8 ? KIND_POINT : KIND_EMPTY;
    end else if (col7_q && ok7_q) begin
      tag8_d.kind  = KIND_OVERLAP;
      tag8_d.ov_sx = ov7_q[0];
      tag8_d.ov_sy = ov7_q[1];
      tag8_d.ov_ex = ov7_q[2];
      tag8_d.ov_ey = ov7_q[3];
    end else begin
      tag8_d.kind = KIND_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // S1: differences
      p1_q     <= p_d;
      ab1_q[0] <= (CW+1)'(p_d[1]) - (CW+1)'(p_d[3]);
      ab1_q[1] <= (CW+1)'(p_d[2]) - (CW+1)'(p_d[0]);
      ab1_q[2] <= (CW+1)'(p_d[5]) - (CW+1)'(p_d[7]);
      ab1_q[3] <= (CW+1)'(p_d[6]) - (CW+1)'(p_d[4]);
      dd1_q[0] <= (CW+1)'(p_d[4]) - (CW+1)'(p_d[0]);
      dd1_q[1] <= (CW+1)'(p_d[5]) - (CW+1)'(p_d[1]);
      dd1_q[2] <= (CW+1)'(p_d[6]) - (CW+1)'(p_d[0]);
      dd1_q[3] <= (CW+1)'(p_d[7]) - (CW+1)'(p_d[1]);
      dd1_q[4] <= (CW+1)'(p_d[2]) - (CW+1)'(p_d[4]);
      dd1_q[5] <= (CW+1)'(p_d[3]) - (CW+1)'(p_d[5]);
      // S2: products, bounding boxes, endpoint order
      pc2_q[0] <= 32'(p1_q[2]) * 32'(p1_q[1]);
      pc2_q[1] <= 32'(p1_q[0]) * 32'(p1_q[3]);
      pc2_q[2] <= 32'(p1_q[6]) * 32'(p1_q[5]);
      pc2_q[3] <= 32'(p1_q[4]) * 32'(p1_q[7]);
      pd2_q[0] <= 34'(ab1_q[0]) * 34'(ab1_q[3]);
      pd2_q[1] <= 34'(ab1_q[2]) * 34'(ab1_q[1]);
      px2_q[0] <= 34'(ab1_q[1]) * 34'(dd1_q[1]);
      px2_q[1] <= 34'(ab1_q[0]) * 34'(dd1_q[0]);
      px2_q[2] <= 34'(ab1_q[1]) * 34'(dd1_q[3]);
      px2_q[3] <= 34'(ab1_q[0]) * 34'(dd1_q[2]);
      px2_q[4] <= 34'(ab1_q[3]) * 34'(dd1_q[1]);
      px2_q[5] <= 34'(ab1_q[2]) * 34'(dd1_q[0]);
      px2_q[6] <= 34'(ab1_q[3]) * 34'(dd1_q[5]);
      px2_q[7] <= 34'(ab1_q[2]) * 34'(dd1_q[4]);
      ab2_q    <= ab1_q;
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < 2; c++) begin
          if (p1_q[4*s+c] < p1_q[4*s+2+c]) begin
            lh2_q[4*s+2*c]   <= p1_q[4*s+c];
            lh2_q[4*s+2*c+1] <= p1_q[4*s+2+c];
          end else begin
            lh2_q[4*s+2*c]   <= p1_q[4*s+2+c];
            lh2_q[4*s+2*c+1] <= p1_q[4*s+c];
          end
        end
        if (lex_lt(p1_q[4*s+2], p1_q[4*s+3], p1_q[4*s], p1_q[4*s+1])) begin
          or2_q[4*s]   <= p1_q[4*s+2];
          or2_q[4*s+1] <= p1_q[4*s+3];
          or2_q[4*s+2] <= p1_q[4*s];
          or2_q[4*s+3] <= p1_q[4*s+1];
        end else begin
          or2_q[4*s]   <= p1_q[4*s];
          or2_q[4*s+1] <= p1_q[4*s+1];
          or2_q[4*s+2] <= p1_q[4*s+2];
          or2_q[4*s+3] <= p1_q[4*s+3];
        end
      end
      // S3: line constants, determinant
      c1_3_q <= 33'(pc2_q[0]) - 33'(pc2_q[1]);
      c2_3_q <= 33'(pc2_q[2]) - 33'(pc2_q[3]);
      d3_q   <= 35'(pd2_q[0]) - 35'(pd2_q[1]);
      col3_q <= col3_d;
      ok3_q  <= ok3_d;
      ab3_q  <= ab2_q;
      lh3_q  <= lh2_q;
      ov3_q  <= ov3_d;
      // S4: numerator products
      q4_q[0] <= 50'(c1_3_q) * 50'(ab3_q[3]);
      q4_q[1] <= 50'(c2_3_q) * 50'(ab3_q[1]);
      q4_q[2] <= 50'(ab3_q[0]) * 50'(c2_3_q);
      q4_q[3] <= 50'(ab3_q[2]) * 50'(c1_3_q);
      d4_q   <= d3_q;
      col4_q <= col3_q;
      ok4_q  <= ok3_q;
      lh4_q  <= lh3_q;
      ov4_q  <= ov3_q;
      // S5: numerators
      xn5_q  <= 51'(q4_q[0]) - 51'(q4_q[1]);
      yn5_q  <= 51'(q4_q[2]) - 51'(q4_q[3]);
      d5_q   <= d4_q;
      col5_q <= col4_q;
      ok5_q  <= ok4_q;
      lh5_q  <= lh4_q;
      ov5_q  <= ov4_q;
      // S6: make the denominator positive
      xn6_q  <= (d5_q < 0) ? -xn5_q : xn5_q;
      yn6_q  <= (d5_q < 0) ? -yn5_q : yn5_q;
      den6_q <= (d5_q < 0) ? -d5_q : d5_q;
      dnz6_q <= d5_q != '0;
      col6_q <= col5_q;
      ok6_q  <= ok5_q;
      lh6_q  <= lh5_q;
      ov6_q  <= ov5_q;
      // S7: scaled box limits
      for (int i = 0; i < 8; i++) begin
        rp7_q[i] <= 52'(lh6_q[i]) * 52'(den6_q);
      end
      xn7_q  <= xn6_q;
      yn7_q  <= yn6_q;
      den7_q <= den6_q;
      dnz7_q <= dnz6_q;
      col7_q <= col6_q;
      ok7_q  <= ok6_q;
      ov7_q  <= ov6_q;
      // S8: magnitudes for the divider
      mx8_q  <= MAG_W'(tag8_d.neg_x ? -xn7_q : xn7_q);
      my8_q  <= MAG_W'(tag8_d.neg_y ? -yn7_q : yn7_q);
      den8_q <= den7_q[DEN_W-1:0];
      tag8_q <= tag8_d;
    end
  end

  segint_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[7]),
    .num_x_i (mx8_q),
    .num_y_i (my8_q),
    .den_i   (den8_q),
    .tag_i   (tag8_q),
    .valid_o (dv_valid),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy),
    .tag_o   (dv_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q <= dv_tag.kind;
      if (dv_tag.kind == KIND_POINT) begin
        px_q <= sat_fix(64'(dv_qx), dv_tag.neg_x);
        py_q <= sat_fix(64'(dv_qy), dv_tag.neg_y);
      end else begin
        px_q <= '0;
        py_q <= '0;
      end
      ov_q[0] <= dv_tag.ov_sx;
      ov_q[1] <= dv_tag.ov_sy;
      ov_q[2] <= dv_tag.ov_ex;
      ov_q[3] <= dv_tag.ov_ey;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign point_x_o         = px_q;
  assign point_y_o         = py_q;
  assign overlap_start_x_o = ov_q[0];
  assign overlap_start_y_o = ov_q[1];
  assign overlap_end_x_o   = ov_q[2];
  assign overlap_end_y_o   = ov_q[3];

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_EMPTY || kind_o == KIND_POINT || kind_o == KIND_OVERLAP))
    else $error("illegal kind");

  a_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_POINT) |-> (point_x_o == '0 && point_y_o == '0))
    else $error("point fields set outside a point result");

  a_ovl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_OVERLAP) |->
      (overlap_start_x_o == '0 && overlap_start_y_o == '0 &&
       overlap_end_x_o == '0 && overlap_end_y_o == '0))
    else $error("overlap fields set outside an overlap result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

endmodule

`default_nettype wire

// ===== design/segint_div.sv =====
// ----------------------------------------------------------------------------
// segint_div
// Pipelined restoring divider, one quotient bit per stage, dividing the x and
// y magnitudes (scaled by 2^FRAC_BITS) by a shared denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module segint_div #(
  parameter int FRAC_BITS = segint_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [segint_pkg::MAG_W-1:0] num_x_i,
  input  wire logic [segint_pkg::MAG_W-1:0] num_y_i,
  input  wire logic [segint_pkg::DEN_W-1:0] den_i,
  input  wire segint_pkg::seg_tag_t         tag_i,
  output logic                              valid_o,
  output logic [segint_pkg::INT_BITS+FRAC_BITS-1:0] quo_x_o,
  output logic [segint_pkg::INT_BITS+FRAC_BITS-1:0] quo_y_o,
  output segint_pkg::seg_tag_t              tag_o
);
  import segint_pkg::*;

  localparam int QB = INT_BITS + FRAC_BITS;
  localparam int RW = DEN_W + 1;
  localparam int NW = MAG_W + FRAC_BITS;

  logic [RW-1:0]    rx_q [QB];
  logic [RW-1:0]    ry_q [QB];
  logic [NW-1:0]    nx_q [QB];
  logic [NW-1:0]    ny_q [QB];
  logic [QB-1:0]    qx_q [QB];
  logic [QB-1:0]    qy_q [QB];
  logic [DEN_W-1:0] dn_q [QB];
  seg_tag_t         tg_q [QB];
  logic [QB-1:0]    vl_q;

  logic [RW-1:0]    rx_d [QB];
  logic [RW-1:0]    ry_d [QB];
  logic [NW-1:0]    nx_in [QB];
  logic [NW-1:0]    ny_in [QB];
  logic [QB-1:0]    qx_d [QB];
  logic [QB-1:0]    qy_d [QB];
  logic [DEN_W-1:0] dn_in [QB];
  seg_tag_t         tg_in [QB];

  logic [NW-1:0] nx0, ny0;

  assign nx0 = NW'(num_x_i) << FRAC_BITS;
  assign ny0 = NW'(num_y_i) << FRAC_BITS;

  always_comb begin
    logic [RW-1:0] rxi, ryi;
    logic [QB-1:0] qxi, qyi;
    logic [RW:0]   tx, ty;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rxi      = RW'(nx0 >> QB);
        ryi      = RW'(ny0 >> QB);
        nx_in[k] = nx0;
        ny_in[k] = ny0;
        qxi      = '0;
        qyi      = '0;
        dn_in[k] = den_i;
        tg_in[k] = tag_i;
      end else begin
        rxi      = rx_q[k-1];
        ryi      = ry_q[k-1];
        nx_in[k] = nx_q[k-1];
        ny_in[k] = ny_q[k-1];
        qxi      = qx_q[k-1];
        qyi      = qy_q[k-1];
        dn_in[k] = dn_q[k-1];
        tg_in[k] = tg_q[k-1];
      end
      tx = {rxi, nx_in[k][QB-1-k]} - (RW+1)'(dn_in[k]);
      ty = {ryi, ny_in[k][QB-1-k]} - (RW+1)'(dn_in[k]);
      rx_d[k] = tx[RW] ? {rxi[RW-2:0], nx_in[k][QB-1-k]} : tx[RW-1:0];
      ry_d[k] = ty[RW] ? {ryi[RW-2:0], ny_in[k][QB-1-k]} : ty[RW-1:0];
      qx_d[k] = {qxi[QB-2:0], ~tx[RW]};
      qy_d[k] = {qyi[QB-2:0], ~ty[RW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[QB-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QB; k++) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        nx_q[k] <= nx_in[k];
        ny_q[k] <= ny_in[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
        dn_q[k] <= dn_in[k];
        tg_q[k] <= tg_in[k];
      end
    end
  end

  assign valid_o = vl_q[QB-1];
  assign quo_x_o = qx_q[QB-1];
  assign quo_y_o = qy_q[QB-1];
  assign tag_o   = tg_q[QB-1];

endmodule

`default_nettype wire
